// ----- design/botwg_pkg.sv -----
// package for body_offset_to_world_goal
// shared types, constants and the cordic arctangent table; no dependencies
package botwg_pkg;

  localparam int MaxIter = 24;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [16:0] TwoPiQ13 = 17'sd51472;
  localparam logic signed [31:0] HalfPiQ29 = 32'sd843314857;
  localparam logic signed [30:0] OneQ28 = 31'sd268435456;

  typedef struct packed {
    logic load_pose;
    logic start;
    logic mul_step;
    logic cordic_init;
    logic cordic_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic mul_last;
    logic cordic_last;
  } stat_t;

  function automatic logic signed [31:0] atan_q29(input logic [4:0] i);
    case (i)
      5'd0: atan_q29 = 32'sd421657428;
      5'd1: atan_q29 = 32'sd248918915;
      5'd2: atan_q29 = 32'sd131521918;
      5'd3: atan_q29 = 32'sd66762579;
      5'd4: atan_q29 = 32'sd33510843;
      5'd5: atan_q29 = 32'sd16771758;
      5'd6: atan_q29 = 32'sd8387925;
      5'd7: atan_q29 = 32'sd4194219;
      5'd8: atan_q29 = 32'sd2097141;
      5'd9: atan_q29 = 32'sd1048575;
      5'd10: atan_q29 = 32'sd524288;
      5'd11: atan_q29 = 32'sd262144;
      5'd12: atan_q29 = 32'sd131072;
      5'd13: atan_q29 = 32'sd65536;
      5'd14: atan_q29 = 32'sd32768;
      5'd15: atan_q29 = 32'sd16384;
      5'd16: atan_q29 = 32'sd8192;
      5'd17: atan_q29 = 32'sd4096;
      5'd18: atan_q29 = 32'sd2048;
      5'd19: atan_q29 = 32'sd1024;
      5'd20: atan_q29 = 32'sd512;
      5'd21: atan_q29 = 32'sd256;
      5'd22: atan_q29 = 32'sd128;
      5'd23: atan_q29 = 32'sd64;
      default: atan_q29 = 32'sd0;
    endcase
  endfunction

endpackage

// ----- design/botwg_if.sv -----
// valid/ready channel interfaces for the input and goal words
// depends on nothing
interface botwg_in_if;
  logic valid;
  logic ready;
  logic command;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [31:0] position_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic signed [15:0] yaw_offset;
  modport source (output valid, command, position_x, position_y, position_z, quat_w,
    quat_x, quat_y, quat_z, offset_x, offset_y, offset_z, yaw_offset, input ready);
  modport sink (input valid, command, position_x, position_y, position_z, quat_w,
    quat_x, quat_y, quat_z, offset_x, offset_y, offset_z, yaw_offset, output ready);
endinterface

interface botwg_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic signed [31:0] goal_z;
  logic signed [15:0] goal_yaw;
  modport source (output valid, goal_x, goal_y, goal_z, goal_yaw, input ready);
  modport sink (input valid, goal_x, goal_y, goal_z, goal_yaw, output ready);
endinterface

// ----- design/body_offset_to_world_goal.sv -----
// body offset to world goal: a move word is turned into a goal word in the following order:
// 9 quaternion products, 9 matrix-offset products, one cordic set-up step,
// the cordic iterations and the yaw wrap
// pose words are only stored and give no goal; one word at a time, the next word can be accepted
// from the cycle after the goal is taken
// synchronous reset clears control, the output valid and the pose store
module body_offset_to_world_goal #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input logic clk,
  input logic rst,
  botwg_in_if.sink in_ch,
  botwg_out_if.source out_ch
);

  botwg_pkg::ctrl_t ctrl;
  botwg_pkg::stat_t stat;
  logic ovalid;

  botwg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_command(in_ch.command),
    .in_ready(in_ch.ready), .out_busy(ovalid), .stat(stat), .ctrl(ctrl)
  );

  botwg_dp #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .position_x(in_ch.position_x),
    .position_y(in_ch.position_y),
    .position_z(in_ch.position_z),
    .quat_w(in_ch.quat_w), .quat_x(in_ch.quat_x),
    .quat_y(in_ch.quat_y), .quat_z(in_ch.quat_z),
    .offset_x(in_ch.offset_x), .offset_y(in_ch.offset_y), .offset_z(in_ch.offset_z),
    .yaw_offset(in_ch.yaw_offset),
    .goal_x(out_ch.goal_x), .goal_y(out_ch.goal_y), .goal_z(out_ch.goal_z),
    .goal_yaw(out_ch.goal_yaw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else begin
      if (ctrl.finish) ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
    end
  end

  assign out_ch.valid = ovalid;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> !in_ch.ready) else $error("input taken while goal pending");
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |=> out_ch.valid) else $error("goal not presented");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.load_pose, ctrl.start, ctrl.mul_step, ctrl.cordic_init, ctrl.cordic_step}))
    else $error("controller commands overlap");

endmodule

// ----- design/botwg_ctrl.sv -----
// controller: sequences pose load, quaternion and matrix/offset products and cordic iterations
// depends on botwg_pkg
module botwg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  input  logic                out_busy,
  input  botwg_pkg::stat_t    stat,
  output botwg_pkg::ctrl_t    ctrl
);

  localparam logic [1:0] Idle = 2'd0;
  localparam logic [1:0] Mul = 2'd1;
  localparam logic [1:0] CInit = 2'd2;
  localparam logic [1:0] Cord = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == Idle) && !out_busy;

  always_comb begin
    state_next = state;
    ctrl = '0;
    case (state)
      Idle: begin
        if (in_valid && in_ready) begin
          if (in_command) begin
            ctrl.start = 1'b1;
            state_next = Mul;
          end else begin
            ctrl.load_pose = 1'b1;
          end
        end
      end
      Mul: begin
        ctrl.mul_step = 1'b1;
        if (stat.mul_last) state_next = CInit;
      end
      CInit: begin
        ctrl.cordic_init = 1'b1;
        state_next = Cord;
      end
      Cord: begin
        ctrl.cordic_step = 1'b1;
        if (stat.cordic_last) begin
          ctrl.finish = 1'b1;
          state_next = Idle;
        end
      end
      default: state_next = Idle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= Idle;
    else state <= state_next;
  end

endmodule

// ----- design/botwg_dp.sv -----
// datapath: pose store, one multiplier for the quaternion products and one for the matrix-offset products, cordic unit
// depends on botwg_pkg
module botwg_dp #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  botwg_pkg::ctrl_t         ctrl,
  output botwg_pkg::stat_t         stat,
  input  logic signed [31:0]       position_x,
  input  logic signed [31:0]       position_y,
  input  logic signed [31:0]       position_z,
  input  logic signed [15:0]       quat_w,
  input  logic signed [15:0]       quat_x,
  input  logic signed [15:0]       quat_y,
  input  logic signed [15:0]       quat_z,
  input  logic signed [31:0]       offset_x,
  input  logic signed [31:0]       offset_y,
  input  logic signed [31:0]       offset_z,
  input  logic signed [15:0]       yaw_offset,
  output logic signed [31:0]       goal_x,
  output logic signed [31:0]       goal_y,
  output logic signed [31:0]       goal_z,
  output logic signed [15:0]       goal_yaw
);

  localparam int IterW = $clog2(CORDIC_ITERATIONS + 1);

  logic signed [31:0] pos [3];
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] dv [3];
  logic signed [15:0] yoff;

  // step sequence: 0..8 quaternion products, 9..17 matrix times offset
  logic [4:0] step;
  logic signed [31:0] prod [9];
  logic signed [15:0] ma, mb;
  logic signed [31:0] mq;
  logic signed [31:0] rent;
  logic signed [28:0] rr;
  logic signed [60:0] rd;
  logic signed [62:0] acc;
  logic [1:0] row, col;
  logic signed [31:0] gsat;
  logic signed [63:0] gsum;

  // products: xx yy zz xy xz yz wx wy wz
  always_comb begin
    case (step)
      5'd0: begin ma = qx; mb = qx; end
      5'd1: begin ma = qy; mb = qy; end
      5'd2: begin ma = qz; mb = qz; end
      5'd3: begin ma = qx; mb = qy; end
      5'd4: begin ma = qx; mb = qz; end
      5'd5: begin ma = qy; mb = qz; end
      5'd6: begin ma = qw; mb = qx; end
      5'd7: begin ma = qw; mb = qy; end
      5'd8: begin ma = qw; mb = qz; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign mq = ma * mb;

  // rotation matrix entry in Q28 (fits 32 bits for |q| <= 1)
  function automatic logic signed [31:0] rmat(input logic [1:0] r, input logic [1:0] c,
                                              input logic signed [31:0] p [9]);
    logic signed [33:0] v;
    begin
      v = '0;
      case ({r, c})
        4'h0: v = 34'(botwg_pkg::OneQ28) - 34'((34'(p[1]) + 34'(p[2])) <<< 1);
        4'h1: v = (34'(p[3]) - 34'(p[8])) <<< 1;
        4'h2: v = (34'(p[4]) + 34'(p[7])) <<< 1;
        4'h4: v = (34'(p[3]) + 34'(p[8])) <<< 1;
        4'h5: v = 34'(botwg_pkg::OneQ28) - 34'((34'(p[0]) + 34'(p[2])) <<< 1);
        4'h6: v = (34'(p[5]) - 34'(p[6])) <<< 1;
        4'h8: v = (34'(p[4]) - 34'(p[7])) <<< 1;
        4'h9: v = (34'(p[5]) + 34'(p[6])) <<< 1;
        4'hA: v = 34'(botwg_pkg::OneQ28) - 34'((34'(p[0]) + 34'(p[1])) <<< 1);
        default: v = '0;
      endcase
      rmat = 32'(v);
    end
  endfunction

  // matrix row and column of each rotation step
  always_comb begin
    case (step)
      5'd9: begin row = 2'd0; col = 2'd0; end
      5'd10: begin row = 2'd0; col = 2'd1; end
      5'd11: begin row = 2'd0; col = 2'd2; end
      5'd12: begin row = 2'd1; col = 2'd0; end
      5'd13: begin row = 2'd1; col = 2'd1; end
      5'd14: begin row = 2'd1; col = 2'd2; end
      5'd15: begin row = 2'd2; col = 2'd0; end
      5'd16: begin row = 2'd2; col = 2'd1; end
      5'd17: begin row = 2'd2; col = 2'd2; end
      default: begin row = 2'd0; col = 2'd0; end
    endcase
  end

  assign rent = rmat(row, col, prod);
  assign rr = 29'((33'(rent) + 33'sd8) >>> 4);
  assign rd = rr * dv[col];
  assign gsum = 64'((acc + 63'(rd) + 63'sd8388608) >>> 24) + 64'(pos[row]);
  assign gsat = (gsum > 64'sd2147483647) ? 32'sh7fffffff :
                (gsum < -64'sd2147483648) ? 32'sh80000000 : 32'(gsum);

  assign stat.mul_last = (step == 5'd17);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= '0; pos[1] <= '0; pos[2] <= '0;
      qw <= '0; qx <= '0; qy <= '0; qz <= '0;
    end else if (ctrl.load_pose) begin
      pos[0] <= position_x; pos[1] <= position_y; pos[2] <= position_z;
      qw <= quat_w; qx <= quat_x; qy <= quat_y; qz <= quat_z;
    end
    if (ctrl.start) begin
      dv[0] <= offset_x; dv[1] <= offset_y; dv[2] <= offset_z;
      yoff <= yaw_offset;
      step <= '0;
      acc <= '0;
    end else if (ctrl.mul_step) begin
      step <= step + 5'd1;
      if (step < 5'd9) prod[step[3:0]] <= mq;
      else if (col == 2'd2) begin
        acc <= '0;
        case (row)
          2'd0: goal_x <= gsat;
          2'd1: goal_y <= gsat;
          default: goal_z <= gsat;
        endcase
      end else acc <= acc + 63'(rd);
    end
  end

  // cordic
  logic signed [35:0] cx, cy;
  logic signed [31:0] cz;
  logic [IterW-1:0] it;
  logic signed [35:0] sy0, cx0, xs, ys;
  logic signed [31:0] zr;
  logic signed [16:0] ysum;

  assign sy0 = (36'(prod[8]) + 36'(prod[3])) <<< 1;
  assign cx0 = 36'(rmat(2'd0, 2'd0, prod));
  assign xs = cx >>> it;
  assign ys = cy >>> it;
  assign stat.cordic_last = (it == IterW'(CORDIC_ITERATIONS));
  assign zr = 32'((33'(cz) + 33'sd32768) >>> 16);
  assign ysum = 17'(zr) + 17'(yoff);

  always_ff @(posedge clk) begin
    if (ctrl.cordic_init) begin
      it <= '0;
      if (cx0 < 0) begin
        if (sy0 >= 0) begin cx <= sy0; cy <= -cx0; cz <= botwg_pkg::HalfPiQ29; end
        else begin cx <= -sy0; cy <= cx0; cz <= -botwg_pkg::HalfPiQ29; end
      end else begin
        cx <= cx0; cy <= sy0; cz <= '0;
      end
    end else if (ctrl.cordic_step && !stat.cordic_last) begin
      it <= it + 1'b1;
      if (cy > 0) begin
        cx <= cx + ys; cy <= cy - xs; cz <= cz + botwg_pkg::atan_q29(5'(it));
      end else if (cy < 0) begin
        cx <= cx - ys; cy <= cy + xs; cz <= cz - botwg_pkg::atan_q29(5'(it));
      end
    end
    if (ctrl.finish) begin
      if (ysum > 17'(botwg_pkg::PiQ13)) goal_yaw <= 16'(ysum - botwg_pkg::TwoPiQ13);
      else if (ysum < -17'(botwg_pkg::PiQ13)) goal_yaw <= 16'(ysum + botwg_pkg::TwoPiQ13);
      else goal_yaw <= 16'(ysum);
    end
  end

endmodule

// ----- tb/sv/body_offset_to_world_goal_test.sv -----
// testbench for body_offset_to_world_goal: random and directed pose/move words, goals checked
// against an in-bench fixed-point predictor of the rotation, saturation and cordic yaw
// depends on botwg_pkg, botwg_if and the block itself
module body_offset_to_world_goal_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Iter = 16;
  localparam int NumRandom = 1800;
  localparam bit CmdPose = 1'b0;
  localparam bit CmdMove = 1'b1;

  typedef struct {
    bit command;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] ox, oy, oz;
    logic signed [15:0] dyaw;
  } word_t;

  typedef struct packed {
    logic signed [31:0] gx, gy, gz;
    logic signed [15:0] gyaw;
  } goal_t;

  typedef struct {
    word_t w;
    bit known;
    goal_t g;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  botwg_in_if in_ch();
  botwg_out_if out_ch();

  body_offset_to_world_goal #(.CORDIC_ITERATIONS(Iter)) u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  logic signed [31:0] pos_store [3];
  logic signed [15:0] quat_store [4];
  goal_t goal_queue [$];
  row_t rows [$];
  int errors = 0;
  int n_goals = 0;
  int n_pose = 0;
  int n_sat = 0;
  bit no_idle = 0;
  bit hold_long = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint heading_q29(longint sy, longint cx);
    longint z, xs, ys, t;
    z = 0;
    if (cx == 0 && sy == 0) return 0;
    if (cx < 0) begin
      if (sy >= 0) begin
        t = sy; sy = -cx; cx = t; z = botwg_pkg::HalfPiQ29;
      end else begin
        t = -sy; sy = cx; cx = t; z = -botwg_pkg::HalfPiQ29;
      end
    end
    for (int i = 0; i < Iter; i++) begin
      xs = cx >>> i;
      ys = sy >>> i;
      if (sy > 0) begin
        cx = cx + ys; sy = sy - xs; z += botwg_pkg::atan_q29(i[4:0]);
      end else if (sy < 0) begin
        cx = cx - ys; sy = sy + xs; z -= botwg_pkg::atan_q29(i[4:0]);
      end
    end
    return z;
  endfunction

  function automatic void predict_goal(word_t wd);
    longint w, x, y, z, r [3][3], d [3], acc, s, yaw, one;
    goal_t g;
    if (wd.command == CmdPose) begin
      pos_store = '{wd.px, wd.py, wd.pz};
      quat_store = '{wd.qw, wd.qx, wd.qy, wd.qz};
      return;
    end
    one = botwg_pkg::OneQ28;
    w = quat_store[0]; x = quat_store[1]; y = quat_store[2]; z = quat_store[3];
    r[0][0] = one - 2 * (y * y + z * z);
    r[0][1] = 2 * (x * y - w * z);
    r[0][2] = 2 * (x * z + w * y);
    r[1][0] = 2 * (x * y + w * z);
    r[1][1] = one - 2 * (x * x + z * z);
    r[1][2] = 2 * (y * z - w * x);
    r[2][0] = 2 * (x * z - w * y);
    r[2][1] = 2 * (y * z + w * x);
    r[2][2] = one - 2 * (x * x + y * y);
    d = '{wd.ox, wd.oy, wd.oz};
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rnd_shift(r[i][j], 4) * d[j];
      s = rnd_shift(acc, 24) + pos_store[i];
      if (s != sat_word(s)) n_sat++;
      s = sat_word(s);
      if (i == 0) g.gx = s[31:0];
      else if (i == 1) g.gy = s[31:0];
      else g.gz = s[31:0];
    end
    yaw = rnd_shift(heading_q29(2 * (w * z + x * y), r[0][0]), 16) + wd.dyaw;
    if (yaw > botwg_pkg::PiQ13) yaw -= botwg_pkg::TwoPiQ13;
    else if (yaw < -botwg_pkg::PiQ13) yaw += botwg_pkg::TwoPiQ13;
    g.gyaw = yaw[15:0];
    goal_queue = {goal_queue, g};
  endfunction

  function automatic word_t pose_word(int px, int py, int pz, int qw, int qx, int qy, int qz);
    word_t wd;
    wd = '{default: '0};
    wd.command = CmdPose;
    wd.px = px; wd.py = py; wd.pz = pz;
    wd.qw = 16'(qw); wd.qx = 16'(qx); wd.qy = 16'(qy); wd.qz = 16'(qz);
    wd.ox = $urandom; wd.oy = $urandom; wd.oz = $urandom; wd.dyaw = 16'($urandom);
    return wd;
  endfunction

  function automatic word_t move_word(int ox, int oy, int oz, int dy);
    word_t wd;
    wd.command = CmdMove;
    wd.px = $urandom; wd.py = $urandom; wd.pz = $urandom;
    wd.qw = 16'($urandom); wd.qx = 16'($urandom);
    wd.qy = 16'($urandom); wd.qz = 16'($urandom);
    wd.ox = ox; wd.oy = oy; wd.oz = oz; wd.dyaw = 16'(dy);
    return wd;
  endfunction

  function automatic word_t random_word();
    word_t wd;
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      wd = pose_word($urandom, $urandom, $urandom, $urandom_range(0, 32768) - 16384,
        $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
        $urandom_range(0, 32768) - 16384);
      if (k == 0) begin
        wd.px = $urandom_range(0, 2000000) - 1000000;
        wd.py = $urandom_range(0, 2000000) - 1000000;
        wd.pz = $urandom_range(0, 2000000) - 1000000;
      end
      if (k == 1) begin
        wd.qx = 16'($urandom_range(0, 8)); wd.qy = 16'($urandom_range(0, 8));
      end
    end else begin
      wd = move_word($urandom, $urandom, $urandom, $urandom_range(0, 51472) - 25736);
      if (k < 7) begin
        wd.ox = $urandom_range(0, 1 << 22) - (1 << 21);
        wd.oy = $urandom_range(0, 1 << 22) - (1 << 21);
        wd.oz = $urandom_range(0, 1 << 22) - (1 << 21);
      end
      if (k == 9) wd.dyaw = 16'($urandom);
    end
    return wd;
  endfunction

  task automatic add_row(word_t wd, bit known = 0, goal_t g = '{default: '0});
    row_t r;
    r.w = wd; r.known = known; r.g = g;
    rows = {rows, r};
  endtask

  task automatic send_word(word_t wd);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= wd.command;
    in_ch.position_x <= wd.px; in_ch.position_y <= wd.py; in_ch.position_z <= wd.pz;
    in_ch.quat_w <= wd.qw; in_ch.quat_x <= wd.qx;
    in_ch.quat_y <= wd.qy; in_ch.quat_z <= wd.qz;
    in_ch.offset_x <= wd.ox; in_ch.offset_y <= wd.oy; in_ch.offset_z <= wd.oz;
    in_ch.yaw_offset <= wd.dyaw;
    do @(posedge clk); while (!in_ch.ready);
    if (wd.command == CmdPose) n_pose++;
    predict_goal(wd);
    @(negedge clk);
  endtask

  // sink side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_long = 0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    goal_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (goal_queue.size() == 0) begin
        $error("goal word with nothing expected");
        errors++;
      end else begin
        e = goal_queue.pop_front();
        n_goals++;
        if (out_ch.goal_x !== e.gx) begin
          $error("goal_x expected %0d got %0d", e.gx, out_ch.goal_x); errors++;
        end
        if (out_ch.goal_y !== e.gy) begin
          $error("goal_y expected %0d got %0d", e.gy, out_ch.goal_y); errors++;
        end
        if (out_ch.goal_z !== e.gz) begin
          $error("goal_z expected %0d got %0d", e.gz, out_ch.goal_z); errors++;
        end
        if (out_ch.goal_yaw !== e.gyaw) begin
          $error("goal_yaw expected %0d got %0d", e.gyaw, out_ch.goal_yaw); errors++;
        end
      end
    end
  end

  // checks the typed-in goals of the table against the predictor's newest entry
  task automatic check_row(row_t r);
    goal_t p;
    if (!r.known) return;
    p = goal_queue[goal_queue.size() - 1];
    if (p !== r.g) begin
      $error("table goal expected %0d %0d %0d %0d predicted %0d %0d %0d %0d",
        r.g.gx, r.g.gy, r.g.gz, r.g.gyaw, p.gx, p.gy, p.gz, p.gyaw);
      errors++;
    end
  endtask

  initial begin
    int wait_cnt;
    in_ch.valid = 1'b0;
    in_ch.command = CmdPose;
    {in_ch.position_x, in_ch.position_y, in_ch.position_z} = '0;
    {in_ch.quat_w, in_ch.quat_x, in_ch.quat_y, in_ch.quat_z} = '0;
    {in_ch.offset_x, in_ch.offset_y, in_ch.offset_z, in_ch.yaw_offset} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero store after reset: identity matrix, yaw 0
    add_row(move_word(65536, -65536, 131072, 0), 1, '{65536, -65536, 131072, 0});
    add_row(move_word(32'h7fffffff, 32'h80000000, 0, 25736), 1,
      '{32'h7fffffff, 32'h80000000, 0, 25736});
    add_row(move_word(0, 0, 0, -16'sd32768), 1, '{0, 0, 0, 18704});
    add_row(move_word(0, 0, 0, 16'sd32767), 1, '{0, 0, 0, -18705});
    add_row(pose_word(32'h7fffffff, 32'h80000000, 100, 16384, 0, 0, 0));
    add_row(move_word(1, -1, 0, 0), 1, '{32'h7fffffff, 32'h80000000, 100, 0});
    add_row(move_word(0, 0, 0, 0));
    add_row(pose_word(0, 0, 0, 11585, 0, 0, 11585));
    add_row(move_word(65536, 0, 0, 25000));
    add_row(pose_word(0, 0, 0, 0, 0, 0, 16384));
    add_row(move_word(65536, 65536, 0, 0));
    add_row(pose_word(0, 0, 0, 0, 0, 0, -16384));
    add_row(move_word(65536, 0, 65536, -25736));
    add_row(pose_word(0, 0, 0, -16384, 0, 0, -16384));
    add_row(move_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0));
    add_row(pose_word(-100, 5, 7, -16384, 16384, -16384, 16384));
    add_row(move_word(32'h80000000, 32'h80000000, 32'h80000000, -25736));
    add_row(pose_word(0, 0, 0, 16384, 16384, 0, 0));
    add_row(move_word(65536, 65536, 65536, 1));
    add_row(pose_word(0, 0, 0, -16384, 0, 16384, 0));
    add_row(move_word(-65536, 12345, -999, -1));
    foreach (rows[i]) begin
      send_word(rows[i].w);
      check_row(rows[i]);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 400) hold_long = 1;
      if (n == 900) begin
        wait_cnt = 0;
        in_ch.valid <= 1'b0;
        do begin
          @(negedge clk); wait_cnt++;
        end while (goal_queue.size() != 0 && wait_cnt < 100000);
      end
      if (n == NumRandom - 200) no_idle = 1;
      send_word(random_word());
    end
    in_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (goal_queue.size() != 0) begin
      @(negedge clk);
      wait_cnt++;
      if (wait_cnt > 20000) begin
        $display("FAILURE");
        $finish;
      end
    end
    repeat (100) @(negedge clk);
    $display("covered %0d pose words and %0d goals, %0d saturated components",
      n_pose, n_goals, n_sat);
    if (errors == 0 && goal_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
